// File: hdl/mpq_pkg.sv
// Shared codes, widths and defaults for the min-priority process queue.
`default_nettype none
package mpq_pkg;

  localparam int unsigned MPQ_DEPTH_DEF = 16;
  localparam int unsigned ID_W          = 8;
  localparam int unsigned PRI_W         = 8;
  localparam int unsigned CNT_OUT_W     = 5;
  localparam int unsigned IN_DATA_W     = 24;
  localparam int unsigned OUT_DATA_W    = 24;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PURGE   = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage
`default_nettype wire

// File: hdl/min_priority_process_queue.sv
// Top level of the min-priority process queue: slot memory and scan/compact sequencer.
//
//  channel | dir | ports                       | contents
//  --------+-----+-----------------------------+-------------------------------------------
//  in      | in  | in_tvalid/in_tready/in_tdata | operation, proc_id, entry_priority
//  out     | out | out_tvalid/out_tready/out_tdata | status, id, priority, count, empty flag
//
// Sequence: enqueue and query go from idle straight to S_DONE. Dequeue and purge on a
// non-empty queue scan the held slots, then, unless a purge finds no match, shift the
// later slots forward one per cycle; S_DONE loads the result register and raises
// out_tvalid, and waits there while the result register is still full.
// Reset (rst_n low, synchronous) empties the queue and the result register; slot contents
// stay. in_tready is high only while idle, also while a result still waits on out_tready.
`default_nettype none
module min_priority_process_queue #(
  parameter int unsigned QUEUE_DEPTH = mpq_pkg::MPQ_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [1:0] operation, [9:2] proc_id, [17:10] entry_priority, [23:18] zero
  input  wire logic [mpq_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [1:0] status, [9:2] out_proc_id, [17:10] out_priority, [22:18] count_after,
  // [23] is_empty
  output logic [mpq_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import mpq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WW = ID_W + PRI_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t               state_r;
  op_t                  op_r;
  logic [ID_W-1:0]      key_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        ptr_r;
  logic                 pend_r;
  logic [AW-1:0]        pend_idx_r;
  logic                 found_r;
  logic [AW-1:0]        best_r;
  logic [ID_W-1:0]      best_id_r;
  logic [PRI_W-1:0]     best_pri_r;
  status_t              res_status_r;

  logic                 out_valid_r;
  status_t              o_status_r;
  logic [ID_W-1:0]      o_id_r;
  logic [PRI_W-1:0]     o_pri_r;
  logic [CNT_OUT_W-1:0] o_cnt_r;
  logic                 o_empty_r;

  // Slot memory: one word is {id, priority}.
  logic [WW-1:0]        slot_mem [QUEUE_DEPTH];
  logic [WW-1:0]        rd_data_r;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WW-1:0]        wr_data;

  op_t                  in_op;
  logic [ID_W-1:0]      in_id;
  logic [PRI_W-1:0]     in_pri;
  logic                 in_xfer;
  logic [ID_W-1:0]      rd_id;
  logic [PRI_W-1:0]     rd_pri;
  logic                 issue;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  assign in_op   = op_t'(in_tdata[1:0]);
  assign in_id   = in_tdata[2 +: ID_W];
  assign in_pri  = in_tdata[2 + ID_W +: PRI_W];
  assign in_xfer = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  assign rd_id  = rd_data_r[PRI_W +: ID_W];
  assign rd_pri = rd_data_r[PRI_W-1:0];

  // Issue a read while the pointer is still below the held count.
  assign issue   = (ptr_r < count_r);
  assign rd_addr = AW'(ptr_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(count_r);
    wr_data = {in_id, in_pri};
    if (in_xfer && in_op == OP_ENQUEUE && count_r < CW'(QUEUE_DEPTH)) begin
      wr_en = 1'b1;
    end else if (state_r == S_SHIFT && pend_r) begin
      // Move the slot just read one place toward the head.
      wr_en   = 1'b1;
      wr_addr = pend_idx_r - AW'(1);
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      ptr_r       <= '0;
    end else begin
      // Drop the result after its transfer unless a new one is loaded in this cycle.
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r         <= in_op;
            key_r        <= in_id;
            best_id_r    <= '0;
            best_pri_r   <= '0;
            best_r       <= '0;
            found_r      <= 1'b0;
            pend_r       <= 1'b0;
            ptr_r        <= '0;
            unique case (in_op)
              OP_ENQUEUE: begin
                state_r <= S_DONE;
                if (count_r < CW'(QUEUE_DEPTH)) begin
                  count_r      <= count_r + CW'(1);
                  res_status_r <= ST_OK;
                end else begin
                  res_status_r <= ST_FULL;
                end
              end
              OP_DEQUEUE, OP_PURGE: begin
                if (count_r == '0) begin
                  res_status_r <= ST_EMPTY;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_SCAN;
                end
              end
              default: begin
                res_status_r <= ST_OK;
                state_r      <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          pend_r     <= issue;
          pend_idx_r <= AW'(ptr_r);
          if (issue) begin
            ptr_r <= ptr_r + CW'(1);
          end
          if (pend_r) begin
            if (op_r == OP_DEQUEUE) begin
              // Strict less-than keeps the oldest on a tie.
              if (pend_idx_r == '0 || rd_pri < best_pri_r) begin
                best_r     <= pend_idx_r;
                best_id_r  <= rd_id;
                best_pri_r <= rd_pri;
              end
            end else if (!found_r && rd_id == key_r) begin
              found_r    <= 1'b1;
              best_r     <= pend_idx_r;
              best_id_r  <= rd_id;
              best_pri_r <= rd_pri;
            end
          end
          if (!issue && !pend_r) begin
            if (op_r == OP_PURGE && !found_r) begin
              res_status_r <= ST_NOTFOUND;
              state_r      <= S_DONE;
            end else begin
              ptr_r   <= CW'(best_r) + CW'(1);
              state_r <= S_SHIFT;
            end
          end
        end

        S_SHIFT: begin
          pend_r     <= issue;
          pend_idx_r <= AW'(ptr_r);
          if (issue) begin
            ptr_r <= ptr_r + CW'(1);
          end
          if (!issue && !pend_r) begin
            count_r <= count_r - CW'(1);
            state_r <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            o_status_r  <= res_status_r;
            o_id_r      <= best_id_r;
            o_pri_r     <= best_pri_r;
            o_cnt_r     <= cnt_ext[CNT_OUT_W-1:0];
            o_empty_r   <= (count_r == '0);
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_empty_r, o_cnt_r, o_pri_r, o_id_r, o_status_r};

endmodule
`default_nettype wire
